FILE: rtl/pfa_pkg.sv
// Shared types and constants for the partition fit allocator.
// No dependencies; used by pfa_ctrl, pfa_datapath and partition_fit_allocator.
package pfa_pkg;

    localparam int SIZE_W     = 16;
    localparam int CMD_W      = 2;
    localparam int POLICY_W   = 2;
    localparam int INDEX_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;

    typedef enum logic [CMD_W-1:0] {
        CMD_CHECK    = 2'd0,
        CMD_ALLOC    = 2'd1,
        CMD_FREE_ALL = 2'd2,
        CMD_NOP      = 2'd3
    } cmd_t;

    typedef enum logic [POLICY_W-1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2,
        POL_NEXT  = 2'd3
    } policy_t;

    typedef struct packed {
        logic start;
        logic step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } ctrl_sts_t;

endpackage

FILE: rtl/pfa_ctrl.sv
// Sequencer for the partition fit allocator: accepts a request, steps the scan,
// commits the result. Depends on pfa_pkg.
module pfa_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                req_valid,
    output logic                req_ready,
    input  pfa_pkg::ctrl_sts_t  sts,
    output pfa_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!sts.last) begin
                    cmd.step = 1'b1;
                end else if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_finish_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> sts.out_free)
        else $error("commit issued while result register is occupied");

    a_one_command: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.start, cmd.step, cmd.finish}))
        else $error("more than one datapath command in a cycle");

    a_start_enters_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> (state_reg == ST_SCAN) && !req_ready)
        else $error("accepted transaction did not enter the scan");

    a_finish_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> req_ready)
        else $error("commit did not return to idle");

endmodule

FILE: rtl/pfa_datapath.sv
// Datapath of the partition fit allocator: size registers, busy flags, scan
// counter, fit compare, choice tracking and result register. Depends on pfa_pkg.
module pfa_datapath #(
    parameter int PARTITIONS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  pfa_pkg::ctrl_cmd_t              cmd,
    output pfa_pkg::ctrl_sts_t              sts,
    input  logic                            cfg_we,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pfa_pkg::SIZE_W-1:0]      cfg_data,
    input  pfa_pkg::cmd_t                   in_cmd,
    input  pfa_pkg::policy_t                in_policy,
    input  logic [pfa_pkg::SIZE_W-1:0]      in_size,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            out_found,
    output logic [pfa_pkg::INDEX_W-1:0]     out_index,
    output logic [pfa_pkg::SIZE_W-1:0]      out_leftover
);

    localparam int IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam logic [IDX_W:0]   PART_N    = (IDX_W+1)'(PARTITIONS);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(PARTITIONS - 1);
    localparam logic [pfa_pkg::CFG_IDX_W:0] CFG_LIMIT = (pfa_pkg::CFG_IDX_W+1)'(PARTITIONS);

    logic [pfa_pkg::SIZE_W-1:0] size_reg [PARTITIONS];
    logic [PARTITIONS-1:0]      busy_reg;
    logic [IDX_W-1:0]           next_start_reg;

    pfa_pkg::cmd_t              cmd_reg;
    pfa_pkg::policy_t           policy_reg;
    logic [pfa_pkg::SIZE_W-1:0] req_reg;
    logic [IDX_W-1:0]           cnt_reg;
    logic                       found_reg, found_next;
    logic [IDX_W-1:0]           pick_reg, pick_next;
    logic [pfa_pkg::SIZE_W-1:0] best_reg, best_next;

    logic                       out_valid_reg;
    logic                       out_found_reg;
    logic [pfa_pkg::INDEX_W-1:0] out_index_reg;
    logic [pfa_pkg::SIZE_W-1:0] out_leftover_reg;

    pfa_pkg::policy_t           rule;
    logic [IDX_W:0]             wrap_sum;
    logic [IDX_W-1:0]           slot;
    logic [pfa_pkg::SIZE_W-1:0] slot_size;
    logic [pfa_pkg::SIZE_W-1:0] rest;
    logic                       fits;
    logic                       take;
    logic                       reports;

    // Check always scans first fit
    assign rule = (cmd_reg == pfa_pkg::CMD_CHECK) ? pfa_pkg::POL_FIRST : policy_reg;

    always_comb begin
        wrap_sum = {1'b0, next_start_reg} + {1'b0, cnt_reg};
        if (rule == pfa_pkg::POL_NEXT) begin
            if (wrap_sum >= PART_N) begin
                slot = IDX_W'(wrap_sum - PART_N);
            end else begin
                slot = wrap_sum[IDX_W-1:0];
            end
        end else begin
            slot = cnt_reg;
        end
    end

    assign slot_size = size_reg[slot];
    assign rest      = slot_size - req_reg;
    assign fits      = (slot_size != '0) && !busy_reg[slot] && (slot_size >= req_reg);

    always_comb begin
        case (rule)
            pfa_pkg::POL_BEST:  take = fits && (!found_reg || rest <= best_reg);
            pfa_pkg::POL_WORST: take = fits && (!found_reg || rest >= best_reg);
            default:            take = fits && !found_reg;
        endcase
        found_next = found_reg || take;
        pick_next  = take ? slot : pick_reg;
        best_next  = take ? rest : best_reg;
    end

    assign reports = (cmd_reg == pfa_pkg::CMD_CHECK) || (cmd_reg == pfa_pkg::CMD_ALLOC);

    assign sts.last     = (cnt_reg == LAST_SLOT);
    assign sts.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PARTITIONS; i++) begin
                size_reg[i] <= '0;
            end
        end else if (cfg_we && ({1'b0, cfg_index} < CFG_LIMIT)) begin
            size_reg[cfg_index[IDX_W-1:0]] <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= '0;
            next_start_reg <= '0;
        end else if (cmd.finish) begin
            if (cmd_reg == pfa_pkg::CMD_FREE_ALL) begin
                busy_reg <= '0;
            end else if (cmd_reg == pfa_pkg::CMD_ALLOC && found_next) begin
                busy_reg[pick_next] <= 1'b1;
                next_start_reg      <= (pick_next == LAST_SLOT) ? '0 : pick_next + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            cmd_reg    <= in_cmd;
            policy_reg <= in_policy;
            req_reg    <= in_size;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            pick_reg  <= '0;
            best_reg  <= '0;
        end else if (cmd.start) begin
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            pick_reg  <= '0;
            best_reg  <= '0;
        end else if (cmd.step) begin
            cnt_reg   <= cnt_reg + 1'b1;
            found_reg <= found_next;
            pick_reg  <= pick_next;
            best_reg  <= best_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_found_reg    <= reports && found_next;
            out_index_reg    <= (reports && found_next) ? pfa_pkg::INDEX_W'(pick_next) : '0;
            out_leftover_reg <= (reports && found_next) ? best_next : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_found    = out_found_reg;
    assign out_index    = out_index_reg;
    assign out_leftover = out_leftover_reg;

    a_commit_loads_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> out_valid_reg)
        else $error("commit did not load the result register");

    a_alloc_marks_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish && cmd_reg == pfa_pkg::CMD_ALLOC && found_next |=> busy_reg[$past(pick_next)])
        else $error("allocated partition not marked busy");

endmodule

FILE: rtl/partition_fit_allocator.sv
// Top level of the fixed-partition fit allocator (first, best, worst, next fit).
// Depends on pfa_pkg, pfa_ctrl and pfa_datapath.
//
//  channel   direction  payload
//  s_axis    in         command, policy, request_size
//  m_axis    out        found, partition_index, leftover
//  cfg       in         partition size register write (index, data)
//
// A transaction is accepted, then compared against each partition in turn, the
// last compare committing the choice. Partitions are scanned one per cycle
// through a single fit comparator, except where the last step stalls.
// A finished result waits in the output register; the scan stalls on its last
// step while that register is full. Reset clears sizes, busy flags and next fit.
module partition_fit_allocator #(
    parameter int PARTITIONS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pfa_pkg::SIZE_W-1:0]        cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [pfa_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // command, policy, request_size
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [pfa_pkg::M_TDATA_W-1:0]     m_axis_tdata   // found, partition_index, leftover
);

    pfa_pkg::ctrl_cmd_t             cmd;
    pfa_pkg::ctrl_sts_t             sts;
    logic                           out_found;
    logic [pfa_pkg::INDEX_W-1:0]    out_index;
    logic [pfa_pkg::SIZE_W-1:0]     out_leftover;

    assign cfg_ready = 1'b1;

    pfa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pfa_datapath #(
        .PARTITIONS (PARTITIONS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_cmd       (pfa_pkg::cmd_t'(s_axis_tdata[1:0])),
        .in_policy    (pfa_pkg::policy_t'(s_axis_tdata[3:2])),
        .in_size      (s_axis_tdata[19:4]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_found    (out_found),
        .out_index    (out_index),
        .out_leftover (out_leftover)
    );

    assign m_axis_tdata = {4'b0000, out_leftover, out_index, out_found};

endmodule

FILE: bench/partition_fit_allocator_tb.sv
// Self-checking bench for partition_fit_allocator: directed and random requests
// under several partition size settings, results checked against an in-bench predictor.
// Depends on pfa_pkg and the partition_fit_allocator RTL.
`timescale 1ns / 100ps

module partition_fit_allocator_tb;

    localparam int NUM_PARTS   = 8;
    localparam int QUIET_LIMIT = 5000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 160;

    typedef struct packed {
        pfa_pkg::cmd_t              cmd;
        pfa_pkg::policy_t           pol;
        logic [pfa_pkg::SIZE_W-1:0] req;
    } request_t;

    typedef struct packed {
        logic                        found;
        logic [pfa_pkg::INDEX_W-1:0] index;
        logic [pfa_pkg::SIZE_W-1:0]  leftover;
    } grant_t;

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [pfa_pkg::SIZE_W-1:0]    cfg_data;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [pfa_pkg::S_TDATA_W-1:0] s_axis_tdata;  // command, policy, request_size
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [pfa_pkg::M_TDATA_W-1:0] m_axis_tdata;  // found, partition_index, leftover

    request_t                   request_queue[$];
    grant_t                     expected_grants[$];
    logic [pfa_pkg::SIZE_W-1:0] part_size[NUM_PARTS];
    logic                       part_busy[NUM_PARTS];
    int                         next_fit_start;

    logic s_taken = 1'b0;
    logic steady  = 1'b0;
    int   mismatches = 0;
    int   quiet_cycles = 0;
    int   n_requests = 0;
    int   n_found = 0;
    int   n_empty = 0;
    int   n_settings = 0;

    partition_fit_allocator #(.PARTITIONS(NUM_PARTS)) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 aclk = ~aclk;

    function automatic bit slot_fits(int i, logic [pfa_pkg::SIZE_W-1:0] req);
        return i < NUM_PARTS && part_size[i] != '0 && !part_busy[i] && part_size[i] >= req;
    endfunction

    // Works out the grant for one request and updates busy marks and next-fit start.
    function automatic grant_t predict_allocation(request_t rq);
        grant_t                     g;
        int                         pick;
        int                         j;
        logic [pfa_pkg::SIZE_W-1:0] best_rest;
        logic [pfa_pkg::SIZE_W-1:0] rest;
        pfa_pkg::policy_t           rule;
        g         = '0;
        pick      = -1;
        best_rest = '0;
        if (rq.cmd == pfa_pkg::CMD_FREE_ALL) begin
            for (int i = 0; i < NUM_PARTS; i++) part_busy[i] = 1'b0;
            return g;
        end
        if (rq.cmd == pfa_pkg::CMD_NOP) return g;
        rule = (rq.cmd == pfa_pkg::CMD_CHECK) ? pfa_pkg::POL_FIRST : rq.pol;
        case (rule)
            pfa_pkg::POL_FIRST: begin
                for (int i = 0; i < NUM_PARTS; i++)
                    if (pick < 0 && slot_fits(i, rq.req)) pick = i;
            end
            pfa_pkg::POL_NEXT: begin
                for (int i = 0; i < NUM_PARTS; i++) begin
                    j = (next_fit_start + i) % NUM_PARTS;
                    if (pick < 0 && slot_fits(j, rq.req)) pick = j;
                end
            end
            default: begin
                for (int i = 0; i < NUM_PARTS; i++) begin
                    if (slot_fits(i, rq.req)) begin
                        rest = part_size[i] - rq.req;
                        // ties go to the later partition
                        if (pick < 0 || (rule == pfa_pkg::POL_BEST ? rest <= best_rest
                                                                   : rest >= best_rest)) begin
                            best_rest = rest;
                            pick      = i;
                        end
                    end
                end
            end
        endcase
        if (pick >= 0) begin
            if (rq.cmd == pfa_pkg::CMD_ALLOC) begin
                part_busy[pick] = 1'b1;
                next_fit_start  = (pick + 1) % NUM_PARTS;
            end
            g.found    = 1'b1;
            g.index    = pick[pfa_pkg::INDEX_W-1:0];
            g.leftover = part_size[pick] - rq.req;
        end
        return g;
    endfunction

    // Driver: input changes on the falling edge.
    always @(negedge aclk) begin
        request_t rq;
        if (!s_axis_tvalid || s_taken) begin
            if (aresetn && request_queue.size() > 0 && (steady || $urandom_range(99) >= 12)) begin
                rq = request_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {{(pfa_pkg::S_TDATA_W - pfa_pkg::SIZE_W - 4){1'b0}},
                                  rq.req, rq.pol, rq.cmd};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= aresetn && (steady || $urandom_range(99) >= 12);
    end

    // Monitor: predicts on input transactions, checks output transactions.
    always @(posedge aclk) begin
        request_t rq;
        grant_t   exp_g;
        grant_t   got;
        s_taken <= s_axis_tvalid && s_axis_tready;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            rq.cmd = pfa_pkg::cmd_t'(s_axis_tdata[1:0]);
            rq.pol = pfa_pkg::policy_t'(s_axis_tdata[3:2]);
            rq.req = s_axis_tdata[4 +: pfa_pkg::SIZE_W];
            expected_grants.push_back(predict_allocation(rq));
            n_requests++;
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.found    = m_axis_tdata[0];
            got.index    = m_axis_tdata[1 +: pfa_pkg::INDEX_W];
            got.leftover = m_axis_tdata[4 +: pfa_pkg::SIZE_W];
            if (expected_grants.size() == 0) begin
                $error("result transaction with nothing expected: %h", m_axis_tdata);
                mismatches++;
            end else begin
                exp_g = expected_grants.pop_front();
                if (got.found !== exp_g.found) begin
                    $error("found: expected %0d, got %0d", exp_g.found, got.found);
                    mismatches++;
                end
                if (got.index !== exp_g.index) begin
                    $error("partition_index: expected %0d, got %0d", exp_g.index, got.index);
                    mismatches++;
                end
                if (got.leftover !== exp_g.leftover) begin
                    $error("leftover: expected %0d, got %0d", exp_g.leftover, got.leftover);
                    mismatches++;
                end
                if (exp_g.found) n_found++;
                else n_empty++;
            end
        end
    end

    // Watchdog on cycles with no transaction on any channel.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d idle cycles", QUIET_LIMIT);
            $display("partition_fit_allocator: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_size(input int idx, input logic [pfa_pkg::SIZE_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx[pfa_pkg::CFG_IDX_W-1:0];
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        part_size[idx] = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_request(input pfa_pkg::cmd_t cmd, input pfa_pkg::policy_t pol,
                               input logic [pfa_pkg::SIZE_W-1:0] req);
        request_t rq;
        rq.cmd = cmd;
        rq.pol = pol;
        rq.req = req;
        request_queue.push_back(rq);
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (request_queue.size() != 0 || expected_grants.size() != 0 || s_axis_tvalid);
    endtask

    // Sizes by setting mode: all max, full random, few small values with ties, sparse.
    function automatic logic [pfa_pkg::SIZE_W-1:0] pick_size(int mode);
        case (mode)
            0:       return '1;
            1:       return pfa_pkg::SIZE_W'($urandom_range(0, 65535));
            2:       return pfa_pkg::SIZE_W'($urandom_range(0, 3) * 16);
            default: return ($urandom_range(3) == 0) ? '0
                                                     : pfa_pkg::SIZE_W'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic request_t random_request();
        request_t                   rq;
        int                         r;
        logic [pfa_pkg::SIZE_W-1:0] s;
        r = $urandom_range(99);
        if (r < 55)      rq.cmd = pfa_pkg::CMD_ALLOC;
        else if (r < 80) rq.cmd = pfa_pkg::CMD_CHECK;
        else if (r < 90) rq.cmd = pfa_pkg::CMD_FREE_ALL;
        else if (r < 95) rq.cmd = pfa_pkg::CMD_NOP;
        else             rq.cmd = pfa_pkg::cmd_t'($urandom_range(0, 3));
        rq.pol = pfa_pkg::policy_t'($urandom_range(0, 3));
        s = part_size[$urandom_range(0, NUM_PARTS - 1)];
        r = $urandom_range(99);
        if (r < 60)      rq.req = s - pfa_pkg::SIZE_W'($urandom_range(0, (s < 4) ? s : 4));
        else if (r < 75) rq.req = s + 1'b1;
        else if (r < 90) rq.req = pfa_pkg::SIZE_W'($urandom());
        else             rq.req = '0;
        return rq;
    endfunction

    initial begin
        logic [pfa_pkg::SIZE_W-1:0] directed_sizes[NUM_PARTS];
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        next_fit_start = 0;
        for (int i = 0; i < NUM_PARTS; i++) begin
            part_size[i] = '0;
            part_busy[i] = 1'b0;
        end
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset sizes: every slot absent
        add_request(pfa_pkg::CMD_CHECK, pfa_pkg::POL_FIRST, '0);
        add_request(pfa_pkg::CMD_ALLOC, pfa_pkg::POL_NEXT, 16'd1);
        wait_drained();

        directed_sizes = '{16'd100, 16'd300, 16'd300, 16'd50, 16'd0, 16'hFFFF, 16'd100, 16'hFFFF};
        for (int i = 0; i < NUM_PARTS; i++) write_size(i, directed_sizes[i]);
        n_settings++;
        add_request(pfa_pkg::CMD_CHECK, pfa_pkg::POL_WORST, '0);
        add_request(pfa_pkg::CMD_CHECK, pfa_pkg::POL_BEST, 16'hFFFF);
        add_request(pfa_pkg::CMD_ALLOC, pfa_pkg::POL_FIRST, 16'd100);
        add_request(pfa_pkg::CMD_ALLOC, pfa_pkg::POL_BEST, 16'd250);     // tie between 1 and 2
        add_request(pfa_pkg::CMD_ALLOC, pfa_pkg::POL_WORST, 16'd1000);   // tie between 5 and 7
        add_request(pfa_pkg::CMD_ALLOC, pfa_pkg::POL_NEXT, 16'd1);       // wraps past the last slot
        add_request(pfa_pkg::CMD_ALLOC, pfa_pkg::POL_NEXT, 16'd40);
        add_request(pfa_pkg::CMD_ALLOC, pfa_pkg::POL_FIRST, 16'hFFFF);
        add_request(pfa_pkg::CMD_ALLOC, pfa_pkg::POL_BEST, 16'hFFFF);    // nothing fits
        add_request(pfa_pkg::CMD_NOP, pfa_pkg::POL_NEXT, 16'hFFFF);
        add_request(pfa_pkg::CMD_CHECK, pfa_pkg::POL_NEXT, 16'd1);
        add_request(pfa_pkg::CMD_FREE_ALL, pfa_pkg::POL_WORST, 16'hFFFF);
        add_request(pfa_pkg::CMD_ALLOC, pfa_pkg::POL_NEXT, '0);          // next fit keeps its start
        add_request(pfa_pkg::CMD_ALLOC, pfa_pkg::POL_WORST, '0);
        add_request(pfa_pkg::CMD_ALLOC, pfa_pkg::POL_BEST, '0);
        add_request(pfa_pkg::CMD_ALLOC, pfa_pkg::POL_FIRST, '0);
        add_request(pfa_pkg::CMD_ALLOC, pfa_pkg::POL_NEXT, '0);
        add_request(pfa_pkg::CMD_ALLOC, pfa_pkg::POL_BEST, 16'd1);
        add_request(pfa_pkg::CMD_ALLOC, pfa_pkg::POL_WORST, 16'd1);
        add_request(pfa_pkg::CMD_ALLOC, pfa_pkg::POL_FIRST, '0);         // all busy
        add_request(pfa_pkg::CMD_CHECK, pfa_pkg::POL_FIRST, '0);
        add_request(pfa_pkg::CMD_FREE_ALL, pfa_pkg::POL_FIRST, '0);
        add_request(pfa_pkg::CMD_CHECK, pfa_pkg::POL_FIRST, 16'd301);
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++) begin
            for (int i = 0; i < NUM_PARTS; i++) write_size(i, pick_size(p % 4));
            n_settings++;
            steady <= (p == 5);
            for (int k = 0; k < PHASE_ITEMS; k++) request_queue.push_back(random_request());
            wait_drained();
        end

        // back to all absent
        for (int i = 0; i < NUM_PARTS; i++) write_size(i, '0);
        n_settings++;
        steady <= 1'b0;
        for (int k = 0; k < 10; k++) request_queue.push_back(random_request());
        wait_drained();

        repeat (40) @(posedge aclk);
        if (expected_grants.size() != 0) begin
            $error("%0d expected results never arrived", expected_grants.size());
            mismatches++;
        end
        $display("%0d requests over %0d size settings; %0d found a partition, %0d did not",
                 n_requests, n_settings, n_found, n_empty);
        if (mismatches == 0) begin
            $display("partition_fit_allocator: match");
        end else begin
            $display("partition_fit_allocator: mismatch");
        end
        $finish;
    end

endmodule

FILE: partition_fit_allocator.f
rtl/pfa_pkg.sv
rtl/pfa_ctrl.sv
rtl/pfa_datapath.sv
rtl/partition_fit_allocator.sv
bench/partition_fit_allocator_tb.sv
